FILE: src/cp2ds_pkg.sv
// Package with the transfer types, constants and lookup tables of the two-digit scanner.
`timescale 1ns / 1ps

package cp2ds_pkg;

  // Scan sequence lengths and the code that blanks both digits.
  localparam int unsigned ScanPhases  = 21;
  localparam int unsigned IconPhases  = 7;
  localparam int unsigned TensBase    = 7;
  localparam int unsigned UnitsBase   = 14;
  localparam logic [6:0]  BlankNumber = 7'd99;

  // Input item: the value to show and the icon enables.
  typedef struct packed {
    logic [6:0] number;
    logic [6:0] icons;
  } scan_in_t;

  // Result item: which pin pair is driven on this tick.
  typedef struct packed {
    logic       lit;
    logic [2:0] source_pin;
    logic [2:0] low_pin;
    logic [4:0] scan_phase;
  } scan_out_t;

  // Segment pattern of one digit, bit 0 is segment a; digits above 9 are blank.
  function automatic logic [6:0] digit_segments(input logic [3:0] digit);
    logic [6:0] seg;
    case (digit)
      4'd0:    seg = 7'b0111111;
      4'd1:    seg = 7'b0000110;
      4'd2:    seg = 7'b1011011;
      4'd3:    seg = 7'b1001111;
      4'd4:    seg = 7'b1100110;
      4'd5:    seg = 7'b1101101;
      4'd6:    seg = 7'b1111101;
      4'd7:    seg = 7'b0000111;
      4'd8:    seg = 7'b1111111;
      4'd9:    seg = 7'b1101111;
      default: seg = 7'b0000000;
    endcase
    return seg;
  endfunction

  // High and low pin of the LED for each phase, packed as {high, low}.
  function automatic logic [5:0] pin_pair(input logic [4:0] phase);
    logic [5:0] pair;
    case (phase)
      5'd0:    pair = {3'd1, 3'd3};
      5'd1:    pair = {3'd2, 3'd3};
      5'd2:    pair = {3'd4, 3'd3};
      5'd3:    pair = {3'd5, 3'd3};
      5'd4:    pair = {3'd5, 3'd4};
      5'd5:    pair = {3'd4, 3'd5};
      5'd6:    pair = {3'd1, 3'd6};
      5'd7:    pair = {3'd2, 3'd1};
      5'd8:    pair = {3'd3, 3'd1};
      5'd9:    pair = {3'd4, 3'd1};
      5'd10:   pair = {3'd5, 3'd1};
      5'd11:   pair = {3'd1, 3'd4};
      5'd12:   pair = {3'd2, 3'd4};
      5'd13:   pair = {3'd3, 3'd4};
      5'd14:   pair = {3'd1, 3'd2};
      5'd15:   pair = {3'd3, 3'd2};
      5'd16:   pair = {3'd4, 3'd2};
      5'd17:   pair = {3'd5, 3'd2};
      5'd18:   pair = {3'd1, 3'd5};
      5'd19:   pair = {3'd2, 3'd5};
      5'd20:   pair = {3'd3, 3'd5};
      default: pair = 6'd0;
    endcase
    return pair;
  endfunction

endpackage

FILE: src/charlieplex_two_digit_scanner.sv
// Top level of the charlieplexed two-digit seven-segment scanner with seven icons.
`timescale 1ns / 1ps

// Each input transfer is one scan tick and yields exactly one result transfer that names
// the LED driven on that tick (or none) and the phase handled. The scan runs through 21
// phases: seven icons, then the seven segments of the tens digit, then those of the units
// digit; a number of 99 limits the scan to the icon phases. The digits are latched from
// the number at phase 0 only. The phase update and the table lookups sit between the
// input handshake and a single result register, and a new tick is taken in every cycle
// in which the result register is empty or being emptied.
module charlieplex_two_digit_scanner
  import cp2ds_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  scan_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output scan_out_t out_data_o
);

  logic [4:0]  phase_q, phase_d;
  logic [3:0]  tens_q, tens_d;
  logic [3:0]  units_q, units_d;
  logic        out_valid_q, out_valid_d;
  scan_out_t   out_data_q, out_data_d;

  logic        in_xfer;
  logic [4:0]  ph;
  logic [4:0]  ph_next;
  logic [13:0] div_prod;
  logic [3:0]  div_tens;
  logic [6:0]  tens_times_ten;
  logic [3:0]  div_units;
  logic [6:0]  seg_tens, seg_units;
  logic [2:0]  seg_idx;
  logic        on;
  logic [5:0]  pair;

  // The result register frees up when it is empty or its transfer completes.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Split the number into digits: multiply by 103/1024 is exact below 179.
  assign div_prod       = {7'd0, in_data_i.number} * 14'd103;
  assign div_tens       = div_prod[13:10];
  assign tens_times_ten = {div_tens, 3'b000} + {2'b00, div_tens, 1'b0};
  assign div_units      = 4'(in_data_i.number - tens_times_ten);

  // Current phase, the digits it shows and whether its LED is on.
  always_comb begin
    ph = (phase_q >= 5'(ScanPhases)) ? 5'd0 : phase_q;

    tens_d  = tens_q;
    units_d = units_q;
    if (in_xfer && ph == 5'd0) begin
      tens_d  = div_tens;
      units_d = div_units;
    end

    seg_tens  = digit_segments(tens_q);
    seg_units = digit_segments(units_q);
    seg_idx   = 3'd0;
    if (ph < 5'(IconPhases)) begin
      seg_idx = ph[2:0];
      on      = in_data_i.icons[seg_idx];
    end else if (ph < 5'(UnitsBase)) begin
      seg_idx = 3'(ph - 5'(TensBase));
      on      = seg_tens[seg_idx];
    end else begin
      seg_idx = 3'(ph - 5'(UnitsBase));
      on      = seg_units[seg_idx];
    end

    pair = pin_pair(ph);
    out_data_d.lit        = on;
    out_data_d.source_pin = on ? pair[5:3] : 3'd0;
    out_data_d.low_pin    = on ? pair[2:0] : 3'd0;
    out_data_d.scan_phase = ph;
  end

  // Phase advance, with the short icon-only loop when the digits are blanked.
  always_comb begin
    ph_next = ph + 5'd1;
    if (in_data_i.number == BlankNumber && ph_next >= 5'(IconPhases)) begin
      ph_next = 5'd0;
    end
    if (ph_next >= 5'(ScanPhases)) begin
      ph_next = 5'd0;
    end
    phase_d = in_xfer ? ph_next : phase_q;
  end

  // Result valid follows the input and output transfers.
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_xfer) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Scan state and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 5'd0;
      tens_q      <= 4'd0;
      units_q     <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      tens_q      <= tens_d;
      units_q     <= units_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload is loaded with each accepted tick.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
